FILE: hw/rtl/sllt_pkg.sv
`default_nettype none

package sllt_pkg;

  // fixed field widths
  localparam int KEY_W = 31;
  localparam int PAY_W = 32;

  // default table size and the matching record count width
  localparam int DEF_CAPACITY = 64;
  localparam int CNT_W        = $clog2(DEF_CAPACITY + 1);

  // operation codes
  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_CHANGE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_DUP  = 2'd2,
    STAT_MISS = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLEAR,
    S_COMMIT,
    S_DONE
  } state_e;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } rec_t;

  // contents of one cell as it travels along the ring
  typedef struct packed {
    logic valid;
    logic mark;
    rec_t rec;
  } entry_t;

  // strobes from the controller to every cell
  typedef struct packed {
    logic shift;
    logic clear;
    logic commit;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sllt_req_if.sv
`default_nettype none

interface sllt_req_if;
  logic                         valid;
  logic                         ready;
  sllt_pkg::kind_e              kind;
  logic [sllt_pkg::KEY_W-1:0]   key;
  logic [sllt_pkg::KEY_W-1:0]   new_key;
  logic [sllt_pkg::PAY_W-1:0]   payload;

  modport source (output valid, output kind, output key, output new_key, output payload,
                  input ready);
  modport sink   (input valid, input kind, input key, input new_key, input payload,
                  output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sllt_res_if.sv
`default_nettype none

interface sllt_res_if #(
  parameter int CntW = sllt_pkg::CNT_W
);
  logic              valid;
  logic              ready;
  sllt_pkg::status_e status;
  logic [CntW-1:0]   count;
  logic              full_res;
  logic              empty_res;

  modport source (output valid, output status, output count, output full_res,
                  output empty_res, input ready);
  modport sink   (input valid, input status, input count, input full_res,
                  input empty_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sllt_cell.sv
`default_nettype none

module sllt_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sllt_pkg::cell_ctl_t ctl_i,
  input  sllt_pkg::entry_t    prev_i,
  input  sllt_pkg::rec_t      load_i,
  output sllt_pkg::entry_t    ent_o
);

  logic           valid_q, valid_d;
  logic           mark_q, mark_d;
  sllt_pkg::rec_t rec_q, rec_d;

  // clear, shift from the left neighbor, or take the new record if marked
  always_comb begin
    valid_d = valid_q;
    mark_d  = mark_q;
    rec_d   = rec_q;
    priority if (ctl_i.clear) begin
      valid_d = 1'b0;
      mark_d  = 1'b0;
    end else if (ctl_i.shift) begin
      valid_d = prev_i.valid;
      mark_d  = prev_i.mark;
      rec_d   = prev_i.rec;
    end else if (ctl_i.commit && mark_q) begin
      valid_d = 1'b1;
      mark_d  = 1'b0;
      rec_d   = load_i;
    end
  end

  // occupancy flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      mark_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      mark_q  <= mark_d;
    end
  end

  // record data
  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign ent_o.valid = valid_q;
  assign ent_o.mark  = mark_q;
  assign ent_o.rec   = rec_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sllt_ctrl.sv
`default_nettype none

module sllt_ctrl #(
  parameter int CAPACITY = sllt_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  sllt_req_if.sink            req_i,
  sllt_res_if.source          res_o,
  input  sllt_pkg::entry_t    tail_i,
  output sllt_pkg::entry_t    feed_o,
  output sllt_pkg::rec_t      load_o,
  output sllt_pkg::cell_ctl_t ctl_o
);

  localparam int StepW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int ResW  = sllt_pkg::CNT_W;
  localparam logic [StepW-1:0] LastStep = StepW'(CAPACITY - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(CAPACITY);

  sllt_pkg::state_e           state_q, state_d;
  logic [StepW-1:0]           step_q, step_d;
  sllt_pkg::kind_e            kind_q, kind_d;
  logic [sllt_pkg::KEY_W-1:0] key_q, key_d;
  logic [sllt_pkg::KEY_W-1:0] nkey_q, nkey_d;
  logic [sllt_pkg::PAY_W-1:0] pay_q, pay_d;
  logic                       found_q, found_d;
  logic                       dup_q, dup_d;
  logic                       marked_q, marked_d;
  logic [CntW-1:0]            count_q, count_d;
  sllt_pkg::status_e          status_q, status_d;

  logic                       res_valid_q, res_valid_d;
  sllt_pkg::status_e          res_status_q, res_status_d;
  logic [ResW-1:0]            res_count_q, res_count_d;
  logic                       res_full_q, res_full_d;
  logic                       res_empty_q, res_empty_d;

  logic                       req_fire;
  logic                       res_free;
  logic [sllt_pkg::KEY_W-1:0] ins_key;
  logic                       del_hit;
  logic                       dup_hit;
  logic                       keep_valid;

  // request port is open only between operations
  assign req_i.ready = (state_q == sllt_pkg::S_IDLE);

  // handshake and per-cycle compare on the entry leaving the ring
  assign req_fire = req_i.valid && req_i.ready;
  assign res_free = !res_valid_q || res_o.ready;
  assign ins_key  = (kind_q == sllt_pkg::KIND_CHANGE) ? nkey_q : key_q;
  assign del_hit  = ((kind_q == sllt_pkg::KIND_DELETE) || (kind_q == sllt_pkg::KIND_CHANGE))
                    && tail_i.valid && (tail_i.rec.key == key_q);
  assign dup_hit  = ((kind_q == sllt_pkg::KIND_INSERT) || (kind_q == sllt_pkg::KIND_CHANGE))
                    && tail_i.valid && (tail_i.rec.key == ins_key) && !del_hit;
  assign keep_valid = tail_i.valid && !del_hit;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sllt_pkg::S_IDLE: begin
        if (req_fire) begin
          priority if (req_i.kind == sllt_pkg::KIND_CLEAR) begin
            state_d = sllt_pkg::S_CLEAR;
          end else if ((req_i.kind == sllt_pkg::KIND_INSERT) && (count_q == FullCnt)) begin
            state_d = sllt_pkg::S_COMMIT;
          end else begin
            state_d = sllt_pkg::S_SCAN;
          end
        end
      end
      sllt_pkg::S_SCAN: begin
        if (step_q == LastStep) state_d = sllt_pkg::S_COMMIT;
      end
      sllt_pkg::S_CLEAR:  state_d = sllt_pkg::S_DONE;
      sllt_pkg::S_COMMIT: state_d = sllt_pkg::S_DONE;
      sllt_pkg::S_DONE: begin
        if (res_free) state_d = sllt_pkg::S_IDLE;
      end
      default: state_d = sllt_pkg::S_IDLE;
    endcase
  end

  // datapath and cell strobes
  always_comb begin
    step_d       = step_q;
    kind_d       = kind_q;
    key_d        = key_q;
    nkey_d       = nkey_q;
    pay_d        = pay_q;
    found_d      = found_q;
    dup_d        = dup_q;
    marked_d     = marked_q;
    count_d      = count_q;
    status_d     = status_q;
    res_valid_d  = res_valid_q;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    res_full_d   = res_full_q;
    res_empty_d  = res_empty_q;
    ctl_o        = '0;

    // entry re-entering the ring: matched key dropped, first hole marked
    feed_o.valid = keep_valid;
    feed_o.mark  = !keep_valid && !marked_q;
    feed_o.rec   = tail_i.rec;
    load_o.key     = ins_key;
    load_o.payload = pay_q;

    if (res_valid_q && res_o.ready) res_valid_d = 1'b0;

    unique case (state_q)
      sllt_pkg::S_IDLE: begin
        if (req_fire) begin
          kind_d   = req_i.kind;
          key_d    = req_i.key;
          nkey_d   = req_i.new_key;
          pay_d    = req_i.payload;
          step_d   = '0;
          found_d  = 1'b0;
          dup_d    = 1'b0;
          marked_d = 1'b0;
        end
      end
      sllt_pkg::S_SCAN: begin
        ctl_o.shift = 1'b1;
        step_d      = step_q + 1'b1;
        if (del_hit) begin
          found_d = 1'b1;
          if (kind_q == sllt_pkg::KIND_CHANGE) pay_d = tail_i.rec.payload;
        end
        if (dup_hit) dup_d = 1'b1;
        if (!keep_valid) marked_d = 1'b1;
      end
      sllt_pkg::S_CLEAR: begin
        ctl_o.clear = 1'b1;
        count_d     = '0;
        status_d    = sllt_pkg::STAT_OK;
      end
      sllt_pkg::S_COMMIT: begin
        unique case (kind_q)
          sllt_pkg::KIND_INSERT: begin
            priority if (count_q == FullCnt) begin
              status_d = sllt_pkg::STAT_FULL;
            end else if (dup_q) begin
              status_d = sllt_pkg::STAT_DUP;
            end else begin
              ctl_o.commit = 1'b1;
              count_d      = count_q + 1'b1;
              status_d     = sllt_pkg::STAT_OK;
            end
          end
          sllt_pkg::KIND_DELETE: begin
            if (found_q) begin
              count_d  = count_q - 1'b1;
              status_d = sllt_pkg::STAT_OK;
            end else begin
              status_d = sllt_pkg::STAT_MISS;
            end
          end
          sllt_pkg::KIND_CHANGE: begin
            // record is dropped for good when the new key is taken
            priority if (!found_q) begin
              status_d = sllt_pkg::STAT_MISS;
            end else if (dup_q) begin
              count_d  = count_q - 1'b1;
              status_d = sllt_pkg::STAT_DUP;
            end else begin
              ctl_o.commit = 1'b1;
              status_d     = sllt_pkg::STAT_OK;
            end
          end
          sllt_pkg::KIND_CLEAR: begin
            status_d = sllt_pkg::STAT_OK;
          end
        endcase
      end
      sllt_pkg::S_DONE: begin
        if (res_free) begin
          res_valid_d  = 1'b1;
          res_status_d = status_q;
          res_count_d  = ResW'(count_q);
          res_full_d   = (count_q == FullCnt);
          res_empty_d  = (count_q == '0);
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sllt_pkg::S_IDLE;
      step_q      <= '0;
      kind_q      <= sllt_pkg::KIND_INSERT;
      found_q     <= 1'b0;
      dup_q       <= 1'b0;
      marked_q    <= 1'b0;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      kind_q      <= kind_d;
      found_q     <= found_d;
      dup_q       <= dup_d;
      marked_q    <= marked_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // operand and result data
  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    nkey_q       <= nkey_d;
    pay_q        <= pay_d;
    status_q     <= status_d;
    res_status_q <= res_status_d;
    res_count_q  <= res_count_d;
    res_full_q   <= res_full_d;
    res_empty_q  <= res_empty_d;
  end

  // result port
  assign res_o.valid     = res_valid_q;
  assign res_o.status    = res_status_q;
  assign res_o.count     = res_count_q;
  assign res_o.full_res  = res_full_q;
  assign res_o.empty_res = res_empty_q;

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_linked_list_table.sv
// insert, delete and change key rotate the whole ring of CAPACITY cells once past the
// compare stage, then commit and load the result register before taking the next request
// clear and insert into a full table skip the rotation: clear or commit, then the result
// one result register decouples the result port; a request is taken while it waits
// asynchronous active-low reset empties every cell and zeroes the count, no sweep follows
`default_nettype none

module sorted_linked_list_table #(
  parameter int CAPACITY = sllt_pkg::DEF_CAPACITY
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sllt_req_if.sink   req_i,
  sllt_res_if.source res_o
);

  sllt_pkg::entry_t    chain   [CAPACITY];
  sllt_pkg::entry_t    cell_in [CAPACITY];
  sllt_pkg::entry_t    feed;
  sllt_pkg::rec_t      load;
  sllt_pkg::cell_ctl_t ctl;

  // controller and compare stage closing the ring
  sllt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .tail_i (chain[CAPACITY-1]),
    .feed_o (feed),
    .load_o (load),
    .ctl_o  (ctl)
  );

  // ring of record cells, each shifting into its right neighbor
  assign cell_in[0] = feed;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign cell_in[i] = chain[i-1];
    end

    sllt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl),
      .prev_i (cell_in[i]),
      .load_i (load),
      .ent_o  (chain[i])
    );
  end

endmodule

`default_nettype wire
